/* design/pffl_pkg.sv */
// ----------------------------------------------------------------------------
// Page frame free list package
// Sizes, request classes, status codes and queue item type shared by the
// front end, the back end and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pffl_pkg;

  localparam int NUM_FRAMES  = 4096;
  localparam int FRAME_SHIFT = 12;
  localparam int ADDR_W      = 24;
  localparam int COUNT_W     = 13;
  localparam int IDX_W       = $clog2(NUM_FRAMES);
  localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED     = 2'd0,
    ST_FREED         = 2'd1,
    ST_OUT_OF_FRAMES = 2'd2,
    ST_REJECTED      = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_FETCH
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } item_t;

endpackage

`default_nettype wire

/* design/pffl_if.sv */
// ----------------------------------------------------------------------------
// Page frame free list channels
// Request channel (command and frame address) and response channel
// (status, granted address and frame counts), each with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pffl_req_if;
  import pffl_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] frame_address;

  modport source (output valid, command, frame_address, input ready);
  modport sink   (input valid, command, frame_address, output ready);
endinterface

interface pffl_rsp_if;
  import pffl_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  granted_address;
  logic [COUNT_W-1:0] free_frames;
  logic [COUNT_W-1:0] used_frames;

  modport source (output valid, status, granted_address, free_frames, used_frames,
                  input ready);
  modport sink   (input valid, status, granted_address, free_frames, used_frames,
                  output ready);
endinterface

`default_nettype wire

/* design/page_frame_free_list_unit.sv */
// ----------------------------------------------------------------------------
// Page frame free list unit
// Last-in-first-out allocator for 4 KiB physical page frames.
// ----------------------------------------------------------------------------
// Each request gives one response. An allocate pops the head frame and
// returns its address; a free of a nonzero, aligned, in-range address
// pushes the frame; other frees are rejected. The response counts are the
// free and in-use totals after the request. A free, a rejected free or an
// allocate on an empty list is finished in the back end's idle state; an
// allocate that pops a frame also passes through the fetch state, as the
// new head comes from a registered read of the link store. Requests are
// taken into a 2-entry queue while an earlier response waits in the output
// register. The link store needs no clearing after reset: an entry is only
// read once a free has written it. Double frees are not detected.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_free_list_unit (
  input  wire logic clk,
  input  wire logic rst,
  pffl_req_if.sink   req,
  pffl_rsp_if.source rsp
);
  import pffl_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  pffl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  pffl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .rsp     (rsp)
  );

  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_ALLOCATED) |->
      (rsp.granted_address != '0 && rsp.granted_address[FRAME_SHIFT-1:0] == '0))
    else $error("allocated frame address is zero or unaligned");

  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_ALLOCATED) |-> (rsp.granted_address == '0))
    else $error("address given with a non-allocate status");

  a_queue_filled: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> q_valid)
    else $error("accepted request missing from the queue");

endmodule

`default_nettype wire

/* design/pffl_front.sv */
// ----------------------------------------------------------------------------
// Page frame free list front end
// Accepts requests, classifies each as allocate, valid free or rejected
// free, and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pffl_front (
  input  wire logic            clk,
  input  wire logic            rst,
  pffl_req_if.sink             req,
  output logic                 q_valid,
  output pffl_pkg::item_t      q_item,
  input  wire logic            q_ready
);
  import pffl_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;
  logic              bad_addr;
  item_t             in_item;

  always_comb begin
    bad_addr = (req.frame_address == '0) ||
               (req.frame_address[FRAME_SHIFT-1:0] != '0) ||
               (32'(req.frame_address[ADDR_W-1:FRAME_SHIFT]) >= NUM_FRAMES);
    in_item.idx = IDX_W'(32'(req.frame_address[ADDR_W-1:FRAME_SHIFT]));
    if (!req.command) begin
      in_item.op = OP_ALLOC;
    end else if (bad_addr) begin
      in_item.op = OP_REJECT;
    end else begin
      in_item.op = OP_FREE;
    end
  end

  assign req.ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != '0);
  assign q_item    = slots[rd_ptr];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/pffl_back.sv */
// ----------------------------------------------------------------------------
// Page frame free list back end
// Carries out queued requests against the link store, the list head and
// the frame counters, and holds each response in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pffl_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire pffl_pkg::item_t q_item,
  output logic                 q_ready,
  pffl_rsp_if.source           rsp
);
  import pffl_pkg::*;

  logic [IDX_W-1:0] link_mem [NUM_FRAMES];
  logic [IDX_W-1:0] rd_data;

  back_state_t      state;
  back_state_t      state_next;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] free_count_next;
  logic [CNT_W-1:0] used_count;
  logic [CNT_W-1:0] used_count_next;

  logic              out_valid;
  logic              out_valid_next;
  status_t           out_status;
  status_t           out_status_next;
  logic [ADDR_W-1:0] out_addr;
  logic [ADDR_W-1:0] out_addr_next;

  logic take;
  logic rd_en;
  logic wr_en;
  logic empty;

  always_comb begin
    state_next      = state;
    head_next       = head;
    free_count_next = free_count;
    used_count_next = used_count;
    out_status_next = out_status;
    out_addr_next   = out_addr;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    empty           = (head == '0) || (32'(head) >= NUM_FRAMES);
    take            = 1'b0;

    case (state)
      BK_IDLE: begin
        take = q_valid && (!out_valid || rsp.ready);
        if (take) begin
          out_addr_next = '0;
          case (q_item.op)
            OP_ALLOC: begin
              if (empty) begin
                out_status_next = ST_OUT_OF_FRAMES;
              end else begin
                out_status_next = ST_ALLOCATED;
                out_addr_next   = ADDR_W'(32'(head) << FRAME_SHIFT);
                rd_en           = 1'b1;
                state_next      = BK_FETCH;
                if (free_count != '0) begin
                  free_count_next = free_count - 1'b1;
                end
                if (used_count < CNT_W'(NUM_FRAMES)) begin
                  used_count_next = used_count + 1'b1;
                end
              end
            end
            OP_FREE: begin
              out_status_next = ST_FREED;
              wr_en           = 1'b1;
              head_next       = q_item.idx;
              if (free_count < CNT_W'(NUM_FRAMES)) begin
                free_count_next = free_count + 1'b1;
              end
              if (used_count != '0) begin
                used_count_next = used_count - 1'b1;
              end
            end
            default: begin
              out_status_next = ST_REJECTED;
            end
          endcase
        end
      end
      BK_FETCH: begin
        head_next  = rd_data;
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    if (take) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign q_ready = take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[q_item.idx] <= head;
    end
    if (rd_en) begin
      rd_data <= link_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      head       <= '0;
      free_count <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_count <= free_count_next;
      used_count <= used_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_addr   <= out_addr_next;
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.granted_address = out_addr;
  assign rsp.free_frames     = COUNT_W'(32'(free_count));
  assign rsp.used_frames     = COUNT_W'(32'(used_count));

endmodule

`default_nettype wire

/* bench/page_frame_free_list_unit_tb.sv */
// ----------------------------------------------------------------------------
// Page frame free list unit testbench
// Drives allocate and free requests into the unit through a queue of pending
// requests, predicts every reply from a private copy of the free list and
// the frame counts, and compares each reply field by field. Directed
// requests cover the empty list, rejected frees and the extreme frame
// addresses. Random requests keep the list well formed with some noise.
// A closing stretch drives the free count into saturation at zero through
// a double free. Both sides idle at random, and the receiver holds off
// twice for a long stretch so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_free_list_unit_tb;
  import pffl_pkg::*;

  localparam logic CMD_ALLOC       = 1'b0;
  localparam logic CMD_FREE        = 1'b1;
  localparam int   RANDOM_REQUESTS = 1870;
  localparam int   SATURATE_STEPS  = 40;
  localparam int   PHASE_LEN       = 800;
  localparam int   HOLD_CYCLES     = 300;
  localparam int   FIRST_HOLD_AT   = 400;
  localparam int   SECOND_HOLD_AT  = 1700;
  localparam int   DRAIN_CYCLES    = 20;
  localparam int   MAX_REPORTS     = 10;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } frame_req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  granted;
    logic [COUNT_W-1:0] free_frames;
    logic [COUNT_W-1:0] used_frames;
  } frame_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pffl_req_if req_ch ();
  pffl_rsp_if rsp_ch ();

  page_frame_free_list_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  frame_req_t frame_requests[$];
  frame_rsp_t frame_replies[$];

  // predicted free list and counts
  logic [IDX_W-1:0] next_free [NUM_FRAMES];
  logic [IDX_W-1:0] head_frame = '0;
  int free_total = 0;
  int used_total = 0;

  // request generator bookkeeping
  bit in_list [NUM_FRAMES];
  int list_stack[$];
  int held_frames[$];

  int requests_taken = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  int holds_begun = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic frame_rsp_t frame_list_apply(input frame_req_t rq);
    frame_rsp_t r;
    logic [ADDR_W-FRAME_SHIFT-1:0] idx;
    idx = rq.address[ADDR_W-1:FRAME_SHIFT];
    r.granted = '0;
    if (rq.command == CMD_ALLOC) begin
      if (head_frame == '0) begin
        r.status = ST_OUT_OF_FRAMES;
      end else begin
        r.status = ST_ALLOCATED;
        r.granted = ADDR_W'(head_frame) << FRAME_SHIFT;
        head_frame = next_free[head_frame];
        if (free_total > 0) free_total = free_total - 1;
        if (used_total < NUM_FRAMES) used_total = used_total + 1;
      end
    end else if (rq.address == '0 || rq.address[FRAME_SHIFT-1:0] != '0 ||
                 int'(idx) >= NUM_FRAMES) begin
      r.status = ST_REJECTED;
    end else begin
      r.status = ST_FREED;
      next_free[idx] = head_frame;
      head_frame = IDX_W'(idx);
      if (free_total < NUM_FRAMES) free_total = free_total + 1;
      if (used_total > 0) used_total = used_total - 1;
    end
    r.free_frames = COUNT_W'(free_total);
    r.used_frames = COUNT_W'(used_total);
    return r;
  endfunction

  function automatic int idle_pct(input bit receiver);
    if (requests_taken < PHASE_LEN) return receiver ? 49 : 6;
    if (requests_taken < 2 * PHASE_LEN) return receiver ? 6 : 49;
    return 0;
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(input int idx);
    return ADDR_W'(idx) << FRAME_SHIFT;
  endfunction

  task automatic add_request(input logic cmd, input logic [ADDR_W-1:0] addr);
    frame_req_t rq;
    rq.command = cmd;
    rq.address = addr;
    frame_requests.push_back(rq);
  endtask

  always @(posedge clk) begin : drive
    logic take;
    frame_req_t rq;
    take = req_ch.valid && req_ch.ready;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (take) begin
        rq.command = req_ch.command;
        rq.address = req_ch.frame_address;
        frame_replies.push_back(frame_list_apply(rq));
        requests_taken <= requests_taken + 1;
        frame_requests.delete(0);
      end
      // hold an offered request until it is taken
      if (!req_ch.valid || take) begin
        if (frame_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          req_ch.valid         <= 1'b1;
          req_ch.command       <= frame_requests[0].command;
          req_ch.frame_address <= frame_requests[0].address;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_begun == 0 && requests_taken >= FIRST_HOLD_AT) ||
                 (holds_begun == 1 && requests_taken >= SECOND_HOLD_AT)) begin
      hold_left   <= HOLD_CYCLES;
      holds_begun <= holds_begun + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin : check
    frame_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (frame_replies.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected reply: status %0d addr %h free %0d used %0d",
                   rsp_ch.status, rsp_ch.granted_address, rsp_ch.free_frames,
                   rsp_ch.used_frames);
      end else begin
        want = frame_replies.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.granted_address !== want.granted ||
            rsp_ch.free_frames !== want.free_frames ||
            rsp_ch.used_frames !== want.used_frames) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS)
            $display("reply mismatch: want status %0d addr %h free %0d used %0d, got status %0d addr %h free %0d used %0d",
                     want.status, want.granted, want.free_frames, want.used_frames,
                     rsp_ch.status, rsp_ch.granted_address, rsp_ch.free_frames,
                     rsp_ch.used_frames);
        end
      end
    end
  end

  initial begin : stimulus
    int idx;
    int pos;
    int pick;
    int tail_allocs;
    logic [ADDR_W-1:0] addr;
    req_ch.valid         = 1'b0;
    req_ch.command       = CMD_ALLOC;
    req_ch.frame_address = '0;
    rsp_ch.ready         = 1'b0;

    add_request(CMD_ALLOC, '0);
    add_request(CMD_FREE, '0);
    add_request(CMD_FREE, 24'h000001);
    add_request(CMD_FREE, '1);
    add_request(CMD_FREE, 24'h000800);
    add_request(CMD_FREE, 24'h555FFF);
    add_request(CMD_FREE, frame_addr(1));
    add_request(CMD_FREE, frame_addr(NUM_FRAMES - 1));
    add_request(CMD_FREE, 24'h555000);
    add_request(CMD_FREE, 24'hAAA000);
    add_request(CMD_ALLOC, '1);
    add_request(CMD_ALLOC, 24'hAAAAAA);
    add_request(CMD_ALLOC, 24'h555555);
    add_request(CMD_ALLOC, '0);
    add_request(CMD_ALLOC, '1);
    add_request(CMD_ALLOC, 24'h000FFF);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(99);
      if (pick < 48) begin
        add_request(CMD_ALLOC, ADDR_W'($urandom));
        if (list_stack.size() != 0) begin
          idx = list_stack.pop_back();
          in_list[idx] = 1'b0;
          held_frames.push_back(idx);
        end
      end else if (pick < 90) begin
        idx = 0;
        if (held_frames.size() != 0 && $urandom_range(3) != 0) begin
          pos = $urandom_range(held_frames.size() - 1);
          idx = held_frames[pos];
          held_frames.delete(pos);
          if (in_list[idx]) idx = 0;
        end
        if (idx == 0) begin
          idx = $urandom_range(NUM_FRAMES - 1, 1);
          while (in_list[idx]) idx = $urandom_range(NUM_FRAMES - 1, 1);
        end
        in_list[idx] = 1'b1;
        list_stack.push_back(idx);
        add_request(CMD_FREE, frame_addr(idx));
      end else begin
        case ($urandom_range(3))
          0: addr = '0;
          1: addr = '1;
          2: addr = ADDR_W'($urandom) | (ADDR_W'(1) << $urandom_range(FRAME_SHIFT - 1));
          default: addr = frame_addr($urandom_range(NUM_FRAMES - 1)) |
                          (ADDR_W'(1) << $urandom_range(FRAME_SHIFT - 1));
        endcase
        add_request(CMD_FREE, addr);
      end
    end

    // double free closes the list into a loop, so allocation never runs dry
    // and the free count runs down to zero and stays there
    tail_allocs = list_stack.size() + 2 + SATURATE_STEPS;
    idx = $urandom_range(NUM_FRAMES - 1, 1);
    add_request(CMD_FREE, frame_addr(idx));
    add_request(CMD_FREE, frame_addr(idx));
    for (int n = 0; n < tail_allocs; n++)
      add_request(CMD_ALLOC, ADDR_W'($urandom));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (frame_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (frame_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && frame_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
design/pffl_pkg.sv
design/pffl_if.sv
design/pffl_front.sv
design/pffl_back.sv
design/page_frame_free_list_unit.sv
bench/page_frame_free_list_unit_tb.sv
